// ===== rtl/lrks_pkg.sv =====
// Package for the keyed record store: sizes, status codes, controller states
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps
package lrks_pkg;

  localparam int SLOTS        = 256;
  localparam int SIDE_DEPTH   = 16;
  localparam int KEY_BITS     = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int ALBUM_BITS   = 31;
  localparam int STAMP_BITS   = 32;
  localparam int SLOT_AW      = $clog2(SLOTS);
  localparam int SIDE_AW      = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int SLOT_CW      = $clog2(SLOTS + 1);
  localparam int SIDE_CW      = $clog2(SIDE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_SIDEFULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIDE_SCAN,
    S_SIDE_RD,
    S_SIDE_MOVE,
    S_MAIN_SCAN,
    S_MAIN_WAIT,
    S_MAIN_RD,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic side_start;   // clear side scan index
    logic side_step;    // advance side scan
    logic side_rd_hit;  // latch side entry at hit index
    logic side_rd_last; // read last side entry
    logic side_move;    // move last entry into hit slot, shrink
    logic side_write;   // write request into side list
    logic main_start;
    logic main_step;
    logic main_rd;      // read hit slot data
    logic main_touch;   // restamp hit slot
    logic main_write;   // write request into slot
    logic resp_load;
    status_t resp_status;
    logic resp_side;    // response from side list latch
    logic resp_main;    // response from main latch
  } lrks_cmd_t;

  typedef struct packed {
    logic side_done;
    logic side_hit;
    logic side_full;
    logic main_done;
    logic main_hit;
    logic main_rd_valid;
    logic key_zero;
    logic is_put;
    logic is_avail;
  } lrks_sts_t;

endpackage

// ===== rtl/lrks_if.sv =====
// Valid/ready channel interfaces for the keyed record store.
// Depends on lrks_pkg.
`timescale 1ns / 1ps
interface lrks_req_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [lrks_pkg::KEY_BITS-1:0]     track_key;
  logic [lrks_pkg::ALBUM_BITS-1:0]   album_number;
  logic                             is_available;
  logic [lrks_pkg::PAYLOAD_BITS-1:0] record_payload;
  modport source (output valid, action, track_key, album_number, is_available,
                  record_payload, input ready);
  modport sink (input valid, action, track_key, album_number, is_available,
                record_payload, output ready);
endinterface

interface lrks_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [lrks_pkg::ALBUM_BITS-1:0]   found_album;
  logic                             found_available;
  logic [lrks_pkg::PAYLOAD_BITS-1:0] found_payload;
  modport source (output valid, status, found_album, found_available,
                  found_payload, input ready);
  modport sink (input valid, status, found_album, found_available,
                found_payload, output ready);
endinterface

// ===== rtl/lrks_ctrl.sv =====
// Controller state machine of the keyed record store.
// Depends on lrks_pkg; drives the datapath by lrks_cmd_t.
`timescale 1ns / 1ps
module lrks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  lrks_pkg::lrks_sts_t sts,
  output lrks_pkg::lrks_cmd_t cmd,
  output logic                busy,
  output logic                resp_valid
);
  import lrks_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_fire) state_next = S_SIDE_SCAN;
      S_SIDE_SCAN: begin
        if (sts.key_zero) state_next = S_RESP;
        else if (sts.side_done) begin
          if (sts.is_put && !sts.is_avail) state_next = S_WRITE;
          else if (sts.side_hit) state_next = S_SIDE_RD;
          else state_next = S_MAIN_SCAN;
        end
      end
      S_SIDE_RD:   state_next = sts.is_put ? S_SIDE_MOVE : S_RESP;
      S_SIDE_MOVE: state_next = S_MAIN_SCAN;
      S_MAIN_SCAN: if (sts.main_done) state_next = S_MAIN_WAIT;
      S_MAIN_WAIT: begin
        if (sts.is_put) state_next = S_WRITE;
        else if (sts.main_hit) state_next = S_MAIN_RD;
        else state_next = S_RESP;
      end
      S_MAIN_RD:   state_next = S_RESP;
      S_WRITE:     state_next = S_RESP;
      S_RESP:      if (out_fire) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.resp_status = ST_OK;
    case (state)
      S_IDLE:      cmd.side_start = in_fire;
      S_SIDE_SCAN: begin
        cmd.side_step = !sts.side_done;
        if (sts.key_zero) begin
          cmd.resp_load   = 1'b1;
          cmd.resp_status = ST_EMPTY;
        end
      end
      S_SIDE_RD: begin
        if (sts.is_put) begin
          cmd.side_rd_last = 1'b1;
        end else begin
          cmd.side_rd_hit = 1'b1;
        end
      end
      S_SIDE_MOVE: begin
        cmd.side_move  = 1'b1;
        cmd.main_start = 1'b1;
      end
      S_MAIN_SCAN: begin
        cmd.main_step  = !sts.main_done;
      end
      S_MAIN_WAIT: begin
        if (!sts.is_put) begin
          if (sts.main_hit) begin
            cmd.main_rd = 1'b1;
          end else begin
            cmd.resp_load   = 1'b1;
            cmd.resp_status = ST_MISS;
          end
        end
      end
      S_MAIN_RD: begin
        cmd.main_touch = 1'b1;
        cmd.resp_load  = 1'b1;
        cmd.resp_main  = 1'b1;
      end
      S_WRITE: begin
        cmd.resp_load = 1'b1;
        if (sts.is_avail) begin
          cmd.main_write = 1'b1;
        end else if (!sts.side_hit && sts.side_full) begin
          cmd.resp_status = ST_SIDEFULL;
        end else begin
          cmd.side_write = 1'b1;
        end
      end
      default: ;
    endcase
    // a side hit on get answers straight from the hit entry
    if (state == S_SIDE_RD && !sts.is_put) begin
      cmd.resp_load = 1'b1;
      cmd.resp_side = 1'b1;
    end
    if (state == S_SIDE_SCAN && sts.side_done && !sts.key_zero && !sts.side_hit &&
        !(sts.is_put && !sts.is_avail)) begin
      cmd.main_start = 1'b1;
    end
  end

  assign busy       = (state != S_IDLE);
  assign resp_valid = (state == S_RESP);

`ifndef SYNTHESIS
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !out_fire |=> resp_valid)
    else $error("response dropped before taken");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.main_write && cmd.side_write))
    else $error("both stores written for one transaction");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == S_IDLE)
    else $error("transaction accepted while busy");
`endif
endmodule

// ===== rtl/lrks_dp.sv =====
// Datapath of the keyed record store: request latch, side list, slot memory,
// scan counters and response register. Depends on lrks_pkg.
`timescale 1ns / 1ps
module lrks_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_fire,
  input  logic                                in_action,
  input  logic [lrks_pkg::KEY_BITS-1:0]       in_key,
  input  logic [lrks_pkg::ALBUM_BITS-1:0]     in_album,
  input  logic                                in_avail,
  input  logic [lrks_pkg::PAYLOAD_BITS-1:0]   in_payload,
  input  lrks_pkg::lrks_cmd_t                 cmd,
  output lrks_pkg::lrks_sts_t                 sts,
  output logic [1:0]                          status,
  output logic [lrks_pkg::ALBUM_BITS-1:0]     found_album,
  output logic                                found_available,
  output logic [lrks_pkg::PAYLOAD_BITS-1:0]   found_payload
);
  import lrks_pkg::*;

  // request latch
  logic                    req_put, req_avail;
  logic [KEY_BITS-1:0]     req_key;
  logic [ALBUM_BITS-1:0]   req_album;
  logic [PAYLOAD_BITS-1:0] req_payload;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_put     <= in_action;
      req_key     <= in_key;
      req_album   <= in_album;
      req_avail   <= in_avail;
      req_payload <= in_payload;
    end
  end

  // side list: small, held in flops, scanned one entry a cycle
  logic [KEY_BITS-1:0]     side_keys     [SIDE_DEPTH];
  logic [ALBUM_BITS-1:0]   side_albums   [SIDE_DEPTH];
  logic [PAYLOAD_BITS-1:0] side_payloads [SIDE_DEPTH];
  logic [SIDE_CW-1:0]      side_filled;
  logic [SIDE_CW-1:0]      side_idx;
  logic                    side_hit;
  logic [SIDE_AW-1:0]      side_pos;
  logic [ALBUM_BITS-1:0]   side_rd_album;
  logic [PAYLOAD_BITS-1:0] side_rd_payload;
  logic [KEY_BITS-1:0]     side_rd_key;
  logic [SIDE_AW-1:0]      side_ptr, side_last, side_wpos;
  logic                    side_done, side_match;

  assign side_ptr   = side_idx[SIDE_AW-1:0];
  assign side_done  = side_hit || (side_idx >= side_filled);
  assign side_match = (side_keys[side_ptr] == req_key) &&
                      ((req_album == '0) || (side_albums[side_ptr] == req_album));
  assign side_last  = SIDE_AW'(side_filled - SIDE_CW'(1));
  assign side_wpos  = side_hit ? side_pos : side_filled[SIDE_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_filled <= '0;
      side_idx    <= '0;
      side_hit    <= 1'b0;
    end else begin
      if (cmd.side_start) begin
        side_idx <= '0;
        side_hit <= 1'b0;
      end else if (cmd.side_step) begin
        if (side_match) begin
          side_hit <= 1'b1;
          side_pos <= side_ptr;
        end else begin
          side_idx <= side_idx + SIDE_CW'(1);
        end
      end
      if (cmd.side_move) begin
        side_filled <= side_filled - SIDE_CW'(1);
      end else if (cmd.side_write && !side_hit) begin
        side_filled <= side_filled + SIDE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.side_rd_hit) begin
      side_rd_album   <= side_albums[side_pos];
      side_rd_payload <= side_payloads[side_pos];
    end else if (cmd.side_rd_last) begin
      side_rd_key     <= side_keys[side_last];
      side_rd_album   <= side_albums[side_last];
      side_rd_payload <= side_payloads[side_last];
    end
    if (cmd.side_move) begin
      side_keys[side_pos]     <= side_rd_key;
      side_albums[side_pos]   <= side_rd_album;
      side_payloads[side_pos] <= side_rd_payload;
    end else if (cmd.side_write) begin
      side_keys[side_wpos]     <= req_key;
      side_albums[side_wpos]   <= req_album;
      side_payloads[side_wpos] <= req_payload;
    end
  end

  // slot memory: one read port for the scan, one write port
  logic [KEY_BITS-1:0]     slot_keys     [SLOTS];
  logic [ALBUM_BITS-1:0]   slot_albums   [SLOTS];
  logic [PAYLOAD_BITS-1:0] slot_payloads [SLOTS];
  logic [STAMP_BITS-1:0]   slot_stamps   [SLOTS];
  logic [SLOT_CW-1:0]      slots_filled;
  logic [STAMP_BITS-1:0]   use_clock;

  logic [SLOT_CW-1:0]      scan_idx;
  logic                    rd_valid;    // registered read in flight
  logic [SLOT_AW-1:0]      rd_addr;
  logic [KEY_BITS-1:0]     rd_key;
  logic [ALBUM_BITS-1:0]   rd_album;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic [STAMP_BITS-1:0]   rd_stamp;
  logic                    main_hit, exact_hit;
  logic [SLOT_AW-1:0]      main_pos, lru_pos;
  logic [STAMP_BITS-1:0]   best_stamp, lru_stamp;
  logic                    issue, scan_end, main_done;
  logic                    mem_rd, mem_wr;
  logic [SLOT_AW-1:0]      mem_ra, mem_wa;
  logic                    want_newest, lru_scan;
  logic                    key_eq, exact_eq;

  // a put with the store full also scans every slot for the oldest stamp
  assign lru_scan    = req_put && (slots_filled == SLOT_CW'(SLOTS));
  assign want_newest = !req_put && (req_album == '0);
  assign scan_end    = (scan_idx >= slots_filled) || (exact_hit && !lru_scan);
  assign issue       = cmd.main_step && !scan_end;
  assign main_done   = scan_end && !rd_valid;
  assign key_eq      = (rd_key == req_key);
  assign exact_eq    = key_eq && (rd_album == req_album);

  assign mem_rd = issue || cmd.main_rd;
  assign mem_ra = cmd.main_rd ? main_pos : scan_idx[SLOT_AW-1:0];
  assign mem_wr = cmd.main_write;
  assign mem_wa = exact_hit ? main_pos :
                  (slots_filled < SLOT_CW'(SLOTS)) ? slots_filled[SLOT_AW-1:0] : lru_pos;

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_key     <= slot_keys[mem_ra];
      rd_album   <= slot_albums[mem_ra];
      rd_payload <= slot_payloads[mem_ra];
      rd_stamp   <= slot_stamps[mem_ra];
    end
    if (mem_wr) begin
      slot_keys[mem_wa]     <= req_key;
      slot_albums[mem_wa]   <= req_album;
      slot_payloads[mem_wa] <= req_payload;
      slot_stamps[mem_wa]   <= use_clock + STAMP_BITS'(1);
    end else if (cmd.main_touch) begin
      slot_stamps[main_pos] <= use_clock + STAMP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_filled <= '0;
      use_clock    <= '0;
      scan_idx     <= '0;
      rd_valid     <= 1'b0;
      main_hit     <= 1'b0;
      exact_hit    <= 1'b0;
    end else begin
      if (cmd.main_start) begin
        scan_idx  <= '0;
        rd_valid  <= 1'b0;
        main_hit  <= 1'b0;
        exact_hit <= 1'b0;
      end else begin
        rd_valid <= issue;
        if (issue) scan_idx <= scan_idx + SLOT_CW'(1);
        if (rd_valid) begin
          if (want_newest) begin
            if (key_eq && (!main_hit || rd_stamp > best_stamp)) begin
              main_hit   <= 1'b1;
              main_pos   <= rd_addr;
              best_stamp <= rd_stamp;
            end
          end else if (exact_eq && !exact_hit) begin
            main_hit  <= 1'b1;
            exact_hit <= 1'b1;
            main_pos  <= rd_addr;
          end
          if (rd_addr == '0 || rd_stamp < lru_stamp) begin
            lru_pos   <= rd_addr;
            lru_stamp <= rd_stamp;
          end
        end
      end
      if (mem_wr || cmd.main_touch) use_clock <= use_clock + STAMP_BITS'(1);
      if (mem_wr && !exact_hit && slots_filled < SLOT_CW'(SLOTS)) begin
        slots_filled <= slots_filled + SLOT_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) rd_addr <= scan_idx[SLOT_AW-1:0];
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      status          <= cmd.resp_status;
      found_album     <= '0;
      found_available <= 1'b0;
      found_payload   <= '0;
      if (cmd.resp_side) begin
        found_album   <= side_albums[side_pos];
        found_payload <= side_payloads[side_pos];
      end else if (cmd.resp_main) begin
        found_album     <= rd_album;
        found_available <= 1'b1;
        found_payload   <= rd_payload;
      end
    end
  end

  assign sts.side_done     = side_done;
  assign sts.side_hit      = side_hit;
  assign sts.side_full     = (side_filled >= SIDE_CW'(SIDE_DEPTH));
  assign sts.main_done     = main_done;
  assign sts.main_hit      = main_hit;
  assign sts.main_rd_valid = rd_valid;
  assign sts.key_zero      = (req_key == '0);
  assign sts.is_put        = req_put;
  assign sts.is_avail      = req_avail;

`ifndef SYNTHESIS
  a_side_bound: assert property (@(posedge clk) disable iff (rst)
    side_filled <= SIDE_CW'(SIDE_DEPTH))
    else $error("side list count overflow");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slots_filled <= SLOT_CW'(SLOTS))
    else $error("slot count overflow");
  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    (mem_wr || cmd.main_touch) |=> use_clock == $past(use_clock) + STAMP_BITS'(1))
    else $error("use clock not advanced on stamp");
`endif
endmodule

// ===== rtl/lru_keyed_record_store.sv =====
// Keyed record store with timestamp LRU replacement: one request, one response.
// After acceptance the side list is scanned one entry a cycle, then, where the
// request needs it, the slot memory, whose one registered read port is issued
// one slot a cycle, with a tail that drains the last read. A new request is
// accepted only while idle, so not before the response has been taken.
// No clearing pass after reset; the block is ready on the first idle cycle.
`timescale 1ns / 1ps
module lru_keyed_record_store (
  input logic  clk,
  input logic  rst,
  lrks_req_if.sink   req,
  lrks_rsp_if.source rsp
);
  import lrks_pkg::*;

  lrks_cmd_t cmd;
  lrks_sts_t sts;
  logic      busy, in_fire, out_fire;

  assign req.ready = !busy;
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = rsp.valid && rsp.ready;

  lrks_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .out_fire   (out_fire),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .resp_valid (rsp.valid)
  );

  lrks_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .in_action       (req.action),
    .in_key          (req.track_key),
    .in_album        (req.album_number),
    .in_avail        (req.is_available),
    .in_payload      (req.record_payload),
    .cmd             (cmd),
    .sts             (sts),
    .status          (rsp.status),
    .found_album     (rsp.found_album),
    .found_available (rsp.found_available),
    .found_payload   (rsp.found_payload)
  );
endmodule

// ===== test/lrks_test_if.sv =====
// Test-side helpers are not needed as separate interfaces; the RTL interfaces
// lrks_req_if / lrks_rsp_if are used directly. Depends on lrks_pkg.
`timescale 1ns / 1ps
package lrks_test_pkg;
  import lrks_pkg::*;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct {
    logic                    action;
    logic [KEY_BITS-1:0]     track_key;
    logic [ALBUM_BITS-1:0]   album_number;
    logic                    is_available;
    logic [PAYLOAD_BITS-1:0] record_payload;
  } request_t;

  typedef struct {
    status_t                 status;
    logic [ALBUM_BITS-1:0]   found_album;
    logic                    found_available;
    logic [PAYLOAD_BITS-1:0] found_payload;
  } answer_t;
endpackage

// ===== test/lru_keyed_record_store_test.sv =====
// Self-checking bench for lru_keyed_record_store: drives random and directed
// get/put transactions, predicts answers in a behavioural cache copy.
// Depends on lrks_pkg, lrks_if and lrks_test_pkg.
`timescale 1ns / 1ps
module lru_keyed_record_store_test;
  import lrks_pkg::*;
  import lrks_test_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  lrks_req_if req ();
  lrks_rsp_if rsp ();

  lru_keyed_record_store dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    forever #1 clk = ~clk;
  end

  // behavioural cache state
  logic [KEY_BITS-1:0]     cache_key [SLOTS];
  logic [ALBUM_BITS-1:0]   cache_album [SLOTS];
  logic [PAYLOAD_BITS-1:0] cache_payload [SLOTS];
  logic [STAMP_BITS-1:0]   cache_stamp [SLOTS];
  int unsigned             cache_used;
  logic [STAMP_BITS-1:0]   lru_clock;
  logic [KEY_BITS-1:0]     session_key [SIDE_DEPTH];
  logic [ALBUM_BITS-1:0]   session_album [SIDE_DEPTH];
  logic [PAYLOAD_BITS-1:0] session_payload [SIDE_DEPTH];
  int unsigned             session_used;

  answer_t pending_answers[$];
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      hold_off = 1'b0;
  bit      answer_drain = 1'b0;
  logic [KEY_BITS-1:0] key_pool [8];

  localparam int WATCHDOG = 40000;

  function automatic int session_find(logic [KEY_BITS-1:0] k, logic [ALBUM_BITS-1:0] a);
    for (int i = 0; i < session_used; i++)
      if (session_key[i] == k && (a == 0 || session_album[i] == a)) return i;
    return -1;
  endfunction

  function automatic int cache_find(logic [KEY_BITS-1:0] k, logic [ALBUM_BITS-1:0] a);
    for (int i = 0; i < cache_used; i++)
      if (cache_key[i] == k && cache_album[i] == a) return i;
    return -1;
  endfunction

  function automatic int cache_newest(logic [KEY_BITS-1:0] k);
    int best;
    best = -1;
    for (int i = 0; i < cache_used; i++)
      if (cache_key[i] == k && (best < 0 || cache_stamp[i] > cache_stamp[best])) best = i;
    return best;
  endfunction

  function automatic answer_t cache_lookup_or_store(request_t r);
    answer_t ans;
    int pos;
    int last;
    ans = '{ST_OK, '0, 1'b0, '0};
    if (r.track_key == 0) begin
      ans.status = ST_EMPTY;
      return ans;
    end
    if (r.action == OP_GET) begin
      pos = session_find(r.track_key, r.album_number);
      if (pos >= 0) begin
        ans.found_album = session_album[pos];
        ans.found_payload = session_payload[pos];
        return ans;
      end
      pos = (r.album_number != 0) ? cache_find(r.track_key, r.album_number)
                                  : cache_newest(r.track_key);
      if (pos < 0) begin
        ans.status = ST_MISS;
        return ans;
      end
      lru_clock++;
      cache_stamp[pos] = lru_clock;
      ans.found_album = cache_album[pos];
      ans.found_available = 1'b1;
      ans.found_payload = cache_payload[pos];
      return ans;
    end
    pos = session_find(r.track_key, r.album_number);
    if (!r.is_available) begin
      if (pos < 0) begin
        if (session_used >= SIDE_DEPTH) begin
          ans.status = ST_SIDEFULL;
          return ans;
        end
        pos = session_used;
        session_used++;
      end
      session_key[pos] = r.track_key;
      session_album[pos] = r.album_number;
      session_payload[pos] = r.record_payload;
      return ans;
    end
    if (pos >= 0) begin
      last = session_used - 1;
      session_key[pos] = session_key[last];
      session_album[pos] = session_album[last];
      session_payload[pos] = session_payload[last];
      session_used--;
    end
    pos = cache_find(r.track_key, r.album_number);
    if (pos < 0) begin
      if (cache_used < SLOTS) begin
        pos = cache_used;
        cache_used++;
      end else begin
        pos = 0;
        for (int i = 1; i < SLOTS; i++)
          if (cache_stamp[i] < cache_stamp[pos]) pos = i;
      end
    end
    lru_clock++;
    cache_key[pos] = r.track_key;
    cache_album[pos] = r.album_number;
    cache_payload[pos] = r.record_payload;
    cache_stamp[pos] = lru_clock;
    return ans;
  endfunction

  // valid stays high into the next call when it offers at once
  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, 14) * int'($urandom_range(0, 3) != 0);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= r.action;
    req.track_key <= r.track_key;
    req.album_number <= r.album_number;
    req.is_available <= r.is_available;
    req.record_payload <= r.record_payload;
    do @(posedge clk); while (!req.ready);
    pending_answers.push_back(cache_lookup_or_store(r));
    @(negedge clk);
  endtask

  // response side: random stalls, plus a long hold-off when asked
  initial begin
    int wait_cycles;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp.ready <= 1'b0;
      end else begin
        wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (wait_cycles > 0) begin
          rsp.ready <= 1'b0;
          repeat (wait_cycles) @(negedge clk);
        end
        rsp.ready <= 1'b1;
        do @(posedge clk); while (!(rsp.valid && rsp.ready) && !hold_off);
      end
    end
  end

  // answer checker
  always @(posedge clk) begin
    answer_t exp;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected answer: status %0d album %0h payload %0h", $realtime,
                 rsp.status, rsp.found_album, rsp.found_payload);
        errors++;
      end else begin
        exp = pending_answers.pop_front();
        if (rsp.status !== exp.status) begin
          $display("%0t status exp %0d got %0d", $realtime, exp.status, rsp.status);
          errors++;
        end
        if (rsp.found_album !== exp.found_album) begin
          $display("%0t album exp %0h got %0h", $realtime, exp.found_album, rsp.found_album);
          errors++;
        end
        if (rsp.found_available !== exp.found_available) begin
          $display("%0t available exp %0b got %0b", $realtime, exp.found_available,
                   rsp.found_available);
          errors++;
        end
        if (rsp.found_payload !== exp.found_payload) begin
          $display("%0t payload exp %0h got %0h", $realtime, exp.found_payload,
                   rsp.found_payload);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [KEY_BITS-1:0] rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  function automatic request_t random_request(int album_span);
    request_t r;
    r.action = 1'($urandom_range(0, 1));
    r.track_key = ($urandom_range(0, 30) == 0) ? '0 : key_pool[$urandom_range(0, 7)];
    r.album_number = ($urandom_range(0, 3) == 0) ? '0 :
                     ALBUM_BITS'($urandom_range(1, album_span));
    r.is_available = $urandom_range(0, 3) != 0;
    r.record_payload = rand_wide();
    return r;
  endfunction

  task automatic test_directed();
    request_t r;
    send_request('{OP_GET, '0, 31'd5, 1'b1, '0});
    send_request('{OP_PUT, '0, 31'd5, 1'b1, '1});
    send_request('{OP_GET, '1, '0, 1'b0, '0});
    send_request('{OP_PUT, '1, '1, 1'b1, '1});
    send_request('{OP_PUT, '1, 31'd1, 1'b1, 64'h0});
    send_request('{OP_GET, '1, '0, 1'b0, '0});
    send_request('{OP_GET, '1, '1, 1'b0, '0});
    send_request('{OP_PUT, 64'h1, 31'd7, 1'b0, 64'h5555_aaaa_5555_aaaa});
    send_request('{OP_GET, 64'h1, '0, 1'b1, '0});
    send_request('{OP_PUT, 64'h1, 31'd7, 1'b0, 64'haaaa_5555_aaaa_5555});
    send_request('{OP_GET, 64'h1, 31'd7, 1'b1, '0});
    send_request('{OP_PUT, 64'h1, '0, 1'b1, 64'h1234});
    send_request('{OP_GET, 64'h1, 31'd7, 1'b1, '0});
    // fill the session list to overflow
    for (int i = 0; i < SIDE_DEPTH + 2; i++) begin
      r = '{OP_PUT, 64'h100 + i, 31'd3, 1'b0, rand_wide()};
      send_request(r);
    end
  endtask

  task automatic test_random(int count, int album_span);
    for (int i = 0; i < count; i++) send_request(random_request(album_span));
  endtask

  // push many distinct keys so the main store fills and evicts
  task automatic test_eviction(int count);
    request_t r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) r = random_request(4);
      else r = '{OP_PUT, rand_wide() | 64'h1, ALBUM_BITS'($urandom()), 1'b1, rand_wide()};
      send_request(r);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(6, 4);
    join
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    req.valid <= 1'b0;
    while (pending_answers.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = OP_GET;
    req.track_key = '0;
    req.album_number = '0;
    req.is_available = 1'b0;
    req.record_payload = '0;
    cache_used = 0;
    lru_clock = '0;
    session_used = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = (i < 2) ? 64'(i + 1) : rand_wide();
    key_pool[7] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random(500, 4);
    test_eviction(340);
    test_random(280, 3);
    drain();
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
